// ===== hdl/jrlvc_pkg.sv =====
// ----------------------------------------------------------------------------
// jrlvc_pkg
// Shared types and constants for the joint rate-limited velocity command block.
// ----------------------------------------------------------------------------
package jrlvc_pkg;

    localparam int JOINTS      = 8;
    localparam int FRAC_BITS   = 16;
    localparam int JOINT_W     = 3;
    localparam int JIDX_W      = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int DATA_W      = 32;
    localparam int GAIN_W      = 31;
    localparam int RATE_W      = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;
    localparam int TRACK_GAIN  = 10;
    // 0.0001 rad expressed in position lsb
    localparam int FEED_THRESH = (1 << FRAC_BITS) / 10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_RATE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIT_MODE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd5;

    // item commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic [RATE_W-1:0] control_rate_hz;
        logic              mit_mode;
        logic [GAIN_W-1:0] max_step;
        logic [GAIN_W-1:0] max_speed;
        logic [GAIN_W-1:0] stiffness_gain;
        logic [GAIN_W-1:0] damping_gain;
    } cfg_t;

    typedef struct packed {
        logic                     cmd;
        logic [JOINT_W-1:0]       joint_index;
        logic signed [DATA_W-1:0] position_command;
        logic signed [DATA_W-1:0] measured_position;
        logic                     measurement_invalid;
    } item_t;

    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic signed [DATA_W-1:0] command;
        logic signed [DATA_W-1:0] velocity;
        logic                     mit_form;
    } result_t;

    typedef struct packed {
        logic                     en;
        logic [JIDX_W-1:0]        idx;
        logic signed [DATA_W-1:0] data;
    } store_wr_t;

endpackage

// ===== hdl/jrlvc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// jrlvc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module jrlvc_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [jrlvc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jrlvc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output jrlvc_pkg::cfg_t                   cfg
);
    import jrlvc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_CONTROL_RATE: cfg_next.control_rate_hz = cfg_data[RATE_W-1:0];
                REG_MIT_MODE:     cfg_next.mit_mode        = cfg_data[0];
                REG_MAX_STEP:     cfg_next.max_step        = cfg_data[GAIN_W-1:0];
                REG_MAX_SPEED:    cfg_next.max_speed       = cfg_data[GAIN_W-1:0];
                REG_STIFFNESS:    cfg_next.stiffness_gain  = cfg_data[GAIN_W-1:0];
                REG_DAMPING:      cfg_next.damping_gain    = cfg_data[GAIN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_rate_hz <= RATE_W'(500);
            cfg_reg.mit_mode        <= 1'b0;
            cfg_reg.max_step        <= GAIN_W'(32768);
            cfg_reg.max_speed       <= GAIN_W'(196608);
            cfg_reg.stiffness_gain  <= GAIN_W'(1966080);
            cfg_reg.damping_gain    <= GAIN_W'(65536);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/jrlvc_cmd_store.sv =====
// ----------------------------------------------------------------------------
// jrlvc_cmd_store
// Previous command per joint, cleared by reset, one write and one read port.
// ----------------------------------------------------------------------------
module jrlvc_cmd_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jrlvc_pkg::store_wr_t                wr,
    input  logic [jrlvc_pkg::JIDX_W-1:0]        rd_idx,
    output logic signed [jrlvc_pkg::DATA_W-1:0] rd_data
);
    import jrlvc_pkg::*;

    logic signed [DATA_W-1:0] prev_reg [JOINTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINTS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            prev_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = prev_reg[rd_idx];

endmodule

// ===== hdl/jrlvc_shaper.sv =====
// ----------------------------------------------------------------------------
// jrlvc_shaper
// Step limiter and velocity former for one control step.
// ----------------------------------------------------------------------------
module jrlvc_shaper (
    input  jrlvc_pkg::item_t                    item,
    input  logic signed [jrlvc_pkg::DATA_W-1:0] prev,
    input  jrlvc_pkg::cfg_t                     cfg,
    output jrlvc_pkg::result_t                  res
);
    import jrlvc_pkg::*;

    localparam int CHG_W = DATA_W + 1;
    localparam int SUM_W = DATA_W + 2;
    localparam int ERR_W = CHG_W + 4;
    localparam int VEL_W = CHG_W + RATE_W + 1;

    logic signed [DATA_W-1:0] meas;
    logic signed [CHG_W-1:0]  err;
    logic signed [CHG_W-1:0]  chg;
    logic [CHG_W-1:0]         chg_mag;
    logic [CHG_W-1:0]         lim;
    logic                     over;
    logic signed [CHG_W-1:0]  chg_lim;
    logic [CHG_W-1:0]         mag_lim;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DATA_W-1:0] sum_sat;
    logic signed [DATA_W-1:0] cmd_new;
    logic signed [VEL_W-1:0]  prod;
    logic signed [ERR_W-1:0]  err_scaled;
    logic                     feed_on;
    logic signed [VEL_W-1:0]  vel_raw;
    logic signed [VEL_W-1:0]  spd;
    logic signed [VEL_W-1:0]  vel;

    always_comb
    begin
        meas    = item.measurement_invalid ? prev : item.measured_position;
        err     = CHG_W'(item.position_command) - CHG_W'(meas);
        chg     = CHG_W'(item.position_command) - CHG_W'(prev);
        chg_mag = chg[CHG_W-1] ? CHG_W'(-chg) : CHG_W'(chg);
        lim     = {2'b00, cfg.max_step};
        over    = chg_mag > lim;
        if (over)
        begin
            chg_lim = chg[CHG_W-1] ? -$signed(lim) : $signed(lim);
            mag_lim = lim;
        end
        else
        begin
            chg_lim = chg;
            mag_lim = chg_mag;
        end

        // saturate prev plus limited change to the signed 32-bit range
        sum = SUM_W'(prev) + SUM_W'(chg_lim);
        if (sum > SUM_W'(34'sh0_7FFF_FFFF))
        begin
            sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (sum < -SUM_W'(34'sh0_8000_0000))
        begin
            sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            sum_sat = sum[DATA_W-1:0];
        end
        cmd_new = over ? sum_sat : item.position_command;

        prod       = VEL_W'(chg_lim) * VEL_W'($signed({1'b0, cfg.control_rate_hz}));
        err_scaled = ERR_W'(err) * ERR_W'(TRACK_GAIN);
        feed_on    = mag_lim > CHG_W'(FEED_THRESH);
        if (cfg.mit_mode)
        begin
            vel_raw = prod;
        end
        else
        begin
            vel_raw = VEL_W'(err_scaled) + (feed_on ? prod : '0);
        end

        spd = $signed({{(VEL_W-GAIN_W){1'b0}}, cfg.max_speed});
        if (vel_raw > spd)
        begin
            vel = spd;
        end
        else if (vel_raw < -spd)
        begin
            vel = -spd;
        end
        else
        begin
            vel = vel_raw;
        end

        res.joint    = item.joint_index;
        res.command  = cmd_new;
        res.velocity = vel[DATA_W-1:0];
        res.mit_form = cfg.mit_mode || (item.joint_index == '0);
    end

endmodule

// ===== hdl/joint_rate_limited_velocity_command.sv =====
// ----------------------------------------------------------------------------
// joint_rate_limited_velocity_command
// Per-joint position rate limiter, P+feedforward velocity; MIT mode has no P term.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_stall   | cmd, joint_index, positions, flag
//  out     | output    | out_valid / out_stall | joint_out, command, velocity, gains
//  cfg     | input     | cfg_write             | cfg_index, cfg_data
//
//  one word per cycle while nothing stalls; a step word is held in the input
//  register after it is accepted and its result is registered at the output as
//  it leaves the input register; a load word gives no result
//  the stored command is updated as a word leaves the input register, so the
//  next word of the same joint sees it without forwarding
//  reset clears the stored commands and loads the register defaults
//  a stalled result holds the output; the input register then holds one step
//  word, and load words keep flowing past a full output
// ----------------------------------------------------------------------------
module joint_rate_limited_velocity_command (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic [jrlvc_pkg::JOINT_W-1:0]       joint_index,
    input  logic signed [jrlvc_pkg::DATA_W-1:0] position_command,
    input  logic signed [jrlvc_pkg::DATA_W-1:0] measured_position,
    input  logic                                measurement_invalid,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [jrlvc_pkg::JOINT_W-1:0]       joint_out,
    output logic signed [jrlvc_pkg::DATA_W-1:0] limited_command,
    output logic signed [jrlvc_pkg::DATA_W-1:0] velocity_out,
    output logic                                mit_form,
    output logic [jrlvc_pkg::GAIN_W-1:0]        stiffness_out,
    output logic [jrlvc_pkg::GAIN_W-1:0]        damping_out,
    input  logic                                cfg_write,
    input  logic [jrlvc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jrlvc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import jrlvc_pkg::*;

    cfg_t                     cfg;
    item_t                    item_reg;
    logic                     item_vld_reg;
    logic                     item_vld_next;
    result_t                  res;
    result_t                  res_reg;
    logic [GAIN_W-1:0]        stiff_reg;
    logic [GAIN_W-1:0]        damp_reg;
    logic                     out_vld_reg;
    logic                     out_vld_next;
    logic signed [DATA_W-1:0] prev;
    store_wr_t                wr;
    logic                     joint_ok;
    logic                     makes_result;
    logic                     out_free;
    logic                     advance;
    logic                     accept;

    jrlvc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    jrlvc_cmd_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_idx  (item_reg.joint_index[JIDX_W-1:0]),
        .rd_data (prev)
    );

    jrlvc_shaper u_shaper (
        .item (item_reg),
        .prev (prev),
        .cfg  (cfg),
        .res  (res)
    );

    always_comb
    begin
        joint_ok     = 32'(item_reg.joint_index) < 32'(JOINTS);
        makes_result = (item_reg.cmd == CMD_STEP) && joint_ok;
        out_free     = !out_vld_reg || !out_stall;
        advance      = item_vld_reg && (!makes_result || out_free);
        in_stall     = item_vld_reg && !advance;
        accept       = in_valid && !in_stall;

        wr.en   = advance && joint_ok;
        wr.idx  = item_reg.joint_index[JIDX_W-1:0];
        wr.data = (item_reg.cmd == CMD_STEP) ? res.command : item_reg.position_command;

        if (accept)
        begin
            item_vld_next = 1'b1;
        end
        else if (advance)
        begin
            item_vld_next = 1'b0;
        end
        else
        begin
            item_vld_next = item_vld_reg;
        end

        if (advance && makes_result)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.cmd                 <= cmd;
            item_reg.joint_index         <= joint_index;
            item_reg.position_command    <= position_command;
            item_reg.measured_position   <= measured_position;
            item_reg.measurement_invalid <= measurement_invalid;
        end
        if (advance && makes_result)
        begin
            res_reg   <= res;
            stiff_reg <= cfg.stiffness_gain;
            damp_reg  <= cfg.damping_gain;
        end
    end

    assign out_valid       = out_vld_reg;
    assign joint_out       = res_reg.joint;
    assign limited_command = res_reg.command;
    assign velocity_out    = res_reg.velocity;
    assign mit_form        = res_reg.mit_form;
    assign stiffness_out   = stiff_reg;
    assign damping_out     = damp_reg;

endmodule

// ===== verif/joint_rate_limited_velocity_command_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// joint_rate_limited_velocity_command_test
// Self-checking bench for the per-joint rate limiter and velocity shaper.
// A queue of load and step words feeds a driver with random gaps. A predictor
// keeps its own stored commands and register copies and computes the expected
// result of each accepted step word. A monitor with random output stalls
// compares every result field. Several register settings are run, from the
// reset defaults through zero and full-scale values, with registers written
// only while the block is empty.
// ----------------------------------------------------------------------------
module joint_rate_limited_velocity_command_test;

    import jrlvc_pkg::*;

    localparam int     CYCLE_LIMIT   = 400000;
    localparam longint WORD_MAX      = 64'sd2147483647;
    localparam longint WORD_MIN      = -64'sd2147483648;
    localparam longint TRACKING_GAIN = 10;
    // 0.0001 rad in position lsb
    localparam longint FEED_MIN_LSB  = (64'sd1 <<< FRAC_BITS) / 10000;

    typedef struct {
        logic [JOINT_W-1:0]       joint;
        logic signed [DATA_W-1:0] command;
        logic signed [DATA_W-1:0] velocity;
        logic                     mit;
        logic [GAIN_W-1:0]        kp;
        logic [GAIN_W-1:0]        kd;
    } shaped_command_t;

    logic                     clk                 = 1'b0;
    logic                     rst_n               = 1'b0;
    logic                     in_valid            = 1'b0;
    logic                     in_stall;
    logic                     cmd                 = CMD_LOAD;
    logic [JOINT_W-1:0]       joint_index         = '0;
    logic signed [DATA_W-1:0] position_command    = '0;
    logic signed [DATA_W-1:0] measured_position   = '0;
    logic                     measurement_invalid = 1'b0;
    logic                     out_valid;
    logic                     out_stall           = 1'b0;
    logic [JOINT_W-1:0]       joint_out;
    logic signed [DATA_W-1:0] limited_command;
    logic signed [DATA_W-1:0] velocity_out;
    logic                     mit_form;
    logic [GAIN_W-1:0]        stiffness_out;
    logic [GAIN_W-1:0]        damping_out;
    logic                     cfg_write           = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index           = '0;
    logic [CFG_DATA_W-1:0]    cfg_data            = '0;

    // register copies, reset values
    logic [RATE_W-1:0] rate_hz   = 14'd500;
    bit                mit_on    = 1'b0;
    logic [GAIN_W-1:0] step_max  = 31'd32768;
    logic [GAIN_W-1:0] speed_max = 31'd196608;
    logic [GAIN_W-1:0] kp_gain   = 31'd1966080;
    logic [GAIN_W-1:0] kd_gain   = 31'd65536;

    longint          held_command [JOINTS];
    longint          gen_command [JOINTS];
    item_t           pending_words [$];
    shaped_command_t expected_results [$];
    int              mismatch_count = 0;
    int              cycle_count    = 0;
    bit              gaps_on        = 1'b1;
    int              send_gap       = 0;
    int              stall_left     = 0;

    joint_rate_limited_velocity_command dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .cmd                 (cmd),
        .joint_index         (joint_index),
        .position_command    (position_command),
        .measured_position   (measured_position),
        .measurement_invalid (measurement_invalid),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .joint_out           (joint_out),
        .limited_command     (limited_command),
        .velocity_out        (velocity_out),
        .mit_form            (mit_form),
        .stiffness_out       (stiffness_out),
        .damping_out         (damping_out),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** joint_rate_limited_velocity_command: FAILED **");
            $finish;
        end
    end

    function automatic longint clip_to_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // updates the stored command; returns 1 when the word yields a result
    function automatic bit shape_command(input item_t w, output shaped_command_t r);
        longint prev, req, meas, err, delta, next_cmd, vel, lim, spd, rate;
        prev = held_command[w.joint_index];
        req  = longint'($signed(w.position_command));
        meas = w.measurement_invalid ? prev : longint'($signed(w.measured_position));
        r    = '{default: '0};
        if (w.cmd == CMD_LOAD)
        begin
            held_command[w.joint_index] = req;
            return 1'b0;
        end
        lim  = longint'(step_max);
        spd  = longint'(speed_max);
        rate = longint'(rate_hz);
        err      = req - meas;
        delta    = req - prev;
        next_cmd = req;
        if ((delta < 0 ? -delta : delta) > lim)
        begin
            delta    = (delta < 0) ? -lim : lim;
            next_cmd = clip_to_word(prev + delta);
        end
        if (mit_on)
            vel = delta * rate;
        else
        begin
            vel = TRACKING_GAIN * err;
            // feedforward only above the dead band, strict compare
            if ((delta < 0 ? -delta : delta) > FEED_MIN_LSB)
                vel += delta * rate;
        end
        if (vel > spd)
            vel = spd;
        if (vel < -spd)
            vel = -spd;
        held_command[w.joint_index] = next_cmd;
        r.joint    = w.joint_index;
        r.command  = next_cmd[DATA_W-1:0];
        r.velocity = vel[DATA_W-1:0];
        r.mit      = mit_on || (w.joint_index == 0);
        r.kp       = kp_gain;
        r.kd       = kd_gain;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // input side: predict on acceptance, then present the next word or a gap
    always @(posedge clk or negedge rst_n)
    begin : word_driver
        item_t           w;
        shaped_command_t r;
        if (!rst_n)
        begin
            in_valid            <= 1'b0;
            cmd                 <= CMD_LOAD;
            joint_index         <= '0;
            position_command    <= '0;
            measured_position   <= '0;
            measurement_invalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                w = '{cmd, joint_index, position_command, measured_position,
                      measurement_invalid};
                if (shape_command(w, r))
                    expected_results.insert(expected_results.size(), r);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (gaps_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    cmd                 <= w.cmd;
                    joint_index         <= w.joint_index;
                    position_command    <= w.position_command;
                    measured_position   <= w.measured_position;
                    measurement_invalid <= w.measurement_invalid;
                    in_valid            <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        shaped_command_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected word, limited_command", limited_command, 0);
            else
            begin
                want = expected_results.pop_front();
                if (joint_out !== want.joint)
                    report_mismatch("joint_out", joint_out, want.joint);
                if (limited_command !== want.command)
                    report_mismatch("limited_command", limited_command, want.command);
                if (velocity_out !== want.velocity)
                    report_mismatch("velocity_out", velocity_out, want.velocity);
                if (mit_form !== want.mit)
                    report_mismatch("mit_form", mit_form, want.mit);
                if (stiffness_out !== want.kp)
                    report_mismatch("stiffness_out", stiffness_out, want.kp);
                if (damping_out !== want.kd)
                    report_mismatch("damping_out", damping_out, want.kd);
            end
        end
    end

    task automatic push_word(input logic c, input int j, input longint req,
                             input longint meas, input bit inv);
        item_t w;
        w.cmd                 = c;
        w.joint_index         = j[JOINT_W-1:0];
        w.position_command    = req[DATA_W-1:0];
        w.measured_position   = meas[DATA_W-1:0];
        w.measurement_invalid = inv;
        gen_command[j] = req;
        pending_words.insert(pending_words.size(), w);
    endtask

    // mostly steps near the last request so the limiter and dead band get exercised
    task automatic queue_random(input int count);
        int     j;
        longint base, req, meas, d;
        repeat (count)
        begin
            j    = $urandom_range(0, JOINTS - 1);
            base = gen_command[j];
            case ($urandom_range(0, 9))
                0, 1:    req = longint'(int'($urandom));
                2, 3, 4: req = base + longint'($urandom_range(0, 40)) - 20;
                5, 6, 7:
                begin
                    d   = longint'(step_max) + longint'($urandom_range(0, 2)) - 1;
                    req = $urandom_range(0, 1) ? base + d : base - d;
                end
                8:       req = base + longint'($urandom_range(0, 65536)) - 32768;
                default: req = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            endcase
            req = clip_to_word(req);
            case ($urandom_range(0, 3))
                0:       meas = longint'(int'($urandom));
                1:       meas = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
                default: meas = clip_to_word(req + longint'($urandom_range(0, 2000)) - 1000);
            endcase
            push_word(($urandom_range(0, 4) == 0) ? CMD_LOAD : CMD_STEP, j, req, meas,
                      $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // call at a rising edge with the block empty
    task automatic program_regs(input int rate, input bit mit, input logic [GAIN_W-1:0] step,
                                input logic [GAIN_W-1:0] speed, input logic [GAIN_W-1:0] kp,
                                input logic [GAIN_W-1:0] kd);
        rate_hz   = rate[RATE_W-1:0];
        mit_on    = mit;
        step_max  = step;
        speed_max = speed;
        kp_gain   = kp;
        kd_gain   = kd;
        put_reg(REG_CONTROL_RATE, CFG_DATA_W'(rate_hz));
        put_reg(REG_MIT_MODE, CFG_DATA_W'(mit));
        put_reg(REG_MAX_STEP, step);
        put_reg(REG_MAX_SPEED, speed);
        put_reg(REG_STIFFNESS, kp);
        put_reg(REG_DAMPING, kd);
        cfg_write <= 1'b0;
    endtask

    // a load word may still sit in the input register after the last result
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [GAIN_W-1:0] pick_limit();
        case ($urandom_range(0, 2))
            0:       return GAIN_W'($urandom_range(0, 64));
            1:       return GAIN_W'($urandom_range(0, 1 << 20));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        for (int j = 0; j < JOINTS; j++)
        begin
            held_command[j] = 0;
            gen_command[j]  = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: step 32768, speed 196608, rate 500
        push_word(CMD_STEP, 0, 0, 0, 1'b0);
        push_word(CMD_LOAD, 1, 100000, 0, 1'b0);
        push_word(CMD_STEP, 1, 100006, 100000, 1'b0);       // change of 6, no feedforward
        push_word(CMD_STEP, 1, 100013, 100013, 1'b0);       // change of 7, feedforward
        push_word(CMD_STEP, 1, 200000, 0, 1'b0);            // limited upward
        push_word(CMD_STEP, 1, -200000, 5, 1'b1);           // limited downward, bad reading
        push_word(CMD_LOAD, 2, WORD_MAX, 0, 1'b0);
        push_word(CMD_STEP, 2, WORD_MAX, WORD_MIN, 1'b0);
        push_word(CMD_LOAD, 3, WORD_MIN, 0, 1'b0);
        push_word(CMD_STEP, 3, WORD_MIN, WORD_MAX, 1'b0);
        push_word(CMD_STEP, 3, WORD_MAX, WORD_MIN, 1'b1);
        push_word(CMD_LOAD, 4, 0, 0, 1'b0);
        push_word(CMD_STEP, 4, 32768, 32768, 1'b0);         // exactly at the limit
        push_word(CMD_STEP, 4, 65537, 0, 1'b0);             // one over the limit
        push_word(CMD_LOAD, 5, -5, 0, 1'b0);
        push_word(CMD_STEP, 5, -32774, 77, 1'b0);
        push_word(CMD_STEP, 6, 1000, 1000, 1'b1);
        push_word(CMD_STEP, 7, -7, -7, 1'b0);
        push_word(CMD_LOAD, 7, 32'sh12345678, 0, 1'b0);
        push_word(CMD_STEP, 7, 32'sh12345672, 32'sh12345678, 1'b0);
        push_word(CMD_LOAD, 0, WORD_MAX, 0, 1'b0);
        push_word(CMD_STEP, 0, WORD_MIN, 0, 1'b0);
        push_word(CMD_STEP, 5, 32'sh55555555, 32'shAAAAAAAA, 1'b0);
        push_word(CMD_LOAD, 6, -1, 0, 1'b0);
        push_word(CMD_STEP, 6, 0, -1, 1'b0);
        queue_random(300);
        wait_idle();

        program_regs(10000, 1'b1, '1, '1, '1, '0);
        queue_random(250);
        wait_idle();

        // zero rate kills every feedforward term, zero step freezes commands
        program_regs(0, 1'b0, '0, '0, '0, '1);
        queue_random(150);
        wait_idle();

        program_regs(1, 1'b0, '1, '1, GAIN_W'($urandom), GAIN_W'($urandom));
        queue_random(250);
        wait_idle();

        for (int p = 0; p < 3; p++)
        begin
            program_regs($urandom_range(1, 10000), 1'($urandom_range(0, 1)), pick_limit(),
                         pick_limit(), GAIN_W'($urandom), GAIN_W'($urandom));
            queue_random(250);
            wait_idle();
        end

        // no gaps or stalls at the end
        gaps_on = 1'b0;
        program_regs(500, 1'b0, 31'd32768, 31'd196608, GAIN_W'($urandom), GAIN_W'($urandom));
        queue_random(200);
        wait_idle();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("** joint_rate_limited_velocity_command: PASSED **");
        else
            $display("** joint_rate_limited_velocity_command: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/jrlvc_pkg.sv
hdl/jrlvc_cfg_regs.sv
hdl/jrlvc_cmd_store.sv
hdl/jrlvc_shaper.sv
hdl/joint_rate_limited_velocity_command.sv
verif/joint_rate_limited_velocity_command_test.sv
